@@ hdl/min_max_median_sorted_set_macros.svh @@
// Assertion macros for the sorted set block.
// Included by min_max_median_sorted_set, which checks its own logic; depends on nothing else.
`ifndef MIN_MAX_MEDIAN_SORTED_SET_MACROS_SVH
`define MIN_MAX_MEDIAN_SORTED_SET_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define MMMS_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define MMMS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ hdl/mmms_pkg.sv @@
// Shared types and codes for the sorted set block.
// Used by mmms_cell, min_max_median_sorted_set and the testbench; depends on nothing.
`default_nettype none

package mmms_pkg;

   typedef logic signed [31:0] data_type;

   localparam logic [2:0] KIND_PEEK    = 3'd0;
   localparam logic [2:0] KIND_INSERT  = 3'd1;
   localparam logic [2:0] KIND_DEL_MIN = 3'd2;
   localparam logic [2:0] KIND_DEL_MAX = 3'd3;
   localparam logic [2:0] KIND_DEL_MED = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_DUP   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0] kind;
      data_type   item_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      data_type   removed_value;
      logic [6:0] element_count;
      logic       set_empty;
      data_type   min_value;
      data_type   max_value;
      data_type   median_value;
   } rsp_type;

   typedef struct packed {
      logic compare_en;
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/min_max_median_sorted_set.sv @@
// Sorted set of distinct signed values with min, max and median removal.
// The result is registered after the compare, update, max-read and median-read steps.
// A new request is taken only back in the idle state, after the compare, shift and
// two reads through the single shared cell read port, and a held response delays it.
// Reset empties the set and returns to the idle state, where the request side is ready.
`default_nettype none
`include "min_max_median_sorted_set_macros.svh"

module min_max_median_sorted_set #(
   parameter int CAPACITY = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mmms_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mmms_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_UPD  = 5'b00100,
      S_RMAX = 5'b01000,
      S_RMED = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]          kind_ff;
   mmms_pkg::data_type  key_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    pos_ff;
   logic [1:0]          status_ff, status_in;
   mmms_pkg::data_type  removed_ff;
   mmms_pkg::data_type  max_ff;
   mmms_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;

   mmms_pkg::data_type  cell_val [CAPACITY];
   logic [CAPACITY-1:0] cell_gt;
   logic [CAPACITY-1:0] cell_eq;
   mmms_pkg::cell_ctrl_type ctrl;

   logic [IDX_W-1:0]    last_idx, med_idx, pos_in, rd_idx;
   mmms_pkg::data_type  rd_data;
   logic                is_remove, is_insert, is_empty, is_full, dup;
   logic                ins_ok, rem_ok, rsp_load;
   logic [CNT_W+6:0]    count_ext;

   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign med_idx   = IDX_W'((count_ff - CNT_W'(1)) >> 1);
   assign is_insert = (kind_ff == mmms_pkg::KIND_INSERT);
   assign is_remove = kind_ff inside {mmms_pkg::KIND_DEL_MIN, mmms_pkg::KIND_DEL_MAX,
                                      mmms_pkg::KIND_DEL_MED};
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign dup       = |cell_eq;
   assign ins_ok    = (state_ff == S_UPD) && is_insert && !dup && !is_full;
   assign rem_ok    = (state_ff == S_UPD) && is_remove && !is_empty;
   assign rsp_load  = (state_ff == S_RMED) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (kind_ff)
         mmms_pkg::KIND_DEL_MIN: pos_in = '0;
         mmms_pkg::KIND_DEL_MAX: pos_in = last_idx;
         default:                pos_in = med_idx;
      endcase
   end

   // One read port over the chain, shared by the removed, max and median reads.
   always_comb begin
      case (state_ff)
         S_CMP:   rd_idx = pos_in;
         S_RMAX:  rd_idx = last_idx;
         default: rd_idx = med_idx;
      endcase
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_idx == IDX_W'(i)) begin
            rd_data = cell_val[i];
         end
      end
   end

   always_comb begin
      ctrl.compare_en = (state_ff == S_CMP);
      ctrl.insert_en  = ins_ok;
      ctrl.remove_en  = rem_ok;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mmms_pkg::data_type left_v, right_v;
      logic               left_g;

      if (i == 0) begin : g_first
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_inner
         assign left_v = cell_val[i-1];
         assign left_g = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_body
         assign right_v = cell_val[i+1];
      end

      mmms_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key_ff),
         .occupied    (CNT_W'(i) < count_ff),
         .tail        (CNT_W'(i) == count_ff),
         .shift_down  (IDX_W'(i) >= pos_ff),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .value       (cell_val[i]),
         .gt          (cell_gt[i]),
         .eq          (cell_eq[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            state_in = S_RMAX;
            if (is_insert) begin
               if (dup) begin
                  status_in = mmms_pkg::STATUS_DUP;
               end else if (is_full) begin
                  status_in = mmms_pkg::STATUS_FULL;
               end else begin
                  status_in = mmms_pkg::STATUS_DONE;
                  count_in  = count_ff + CNT_W'(1);
               end
            end else if (is_empty) begin
               status_in = mmms_pkg::STATUS_EMPTY;
            end else begin
               status_in = mmms_pkg::STATUS_DONE;
               if (is_remove) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         S_RMAX: begin
            state_in = S_RMED;
         end
         S_RMED: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign count_ext = {7'd0, count_ff};

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (req_valid && req_ready) begin
         kind_ff <= req_data.kind;
         key_ff  <= req_data.item_value;
      end
      if (state_ff == S_CMP) begin
         pos_ff     <= pos_in;
         removed_ff <= (is_remove && !is_empty) ? rd_data : '0;
      end
      if (state_ff == S_RMAX) begin
         max_ff <= rd_data;
      end
      if (rsp_load) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.removed_value <= removed_ff;
         rsp_ff.element_count <= count_ext[6:0];
         rsp_ff.set_empty     <= is_empty;
         rsp_ff.min_value     <= is_empty ? '0 : cell_val[0];
         rsp_ff.max_value     <= is_empty ? '0 : max_ff;
         rsp_ff.median_value  <= is_empty ? '0 : rd_data;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MMMS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "stored count beyond capacity")
   `MMMS_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready,
      state_ff == S_CMP, "accepted transaction did not start the compare step")
   `MMMS_ASSERT_NEXT(a_insert_grows, clock, reset, ins_ok,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the count")
   `MMMS_ASSERT_SAME(a_empty_flag, clock, reset,
      rsp_valid_ff && (rsp_ff.status == mmms_pkg::STATUS_EMPTY), rsp_ff.set_empty,
      "empty status reported on a non-empty set")

endmodule

`default_nettype wire

@@ hdl/mmms_cell.sv @@
// One storage cell of the sorted chain: holds a value and its compare flags.
// Depends on mmms_pkg for the data and control types.
`default_nettype none

module mmms_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mmms_pkg::cell_ctrl_type ctrl,
   input  wire mmms_pkg::data_type     key,
   input  wire logic                   occupied,
   input  wire logic                   tail,
   input  wire logic                   shift_down,
   input  wire mmms_pkg::data_type     left_value,
   input  wire logic                   left_gt,
   input  wire mmms_pkg::data_type     right_value,
   output mmms_pkg::data_type          value,
   output logic                        gt,
   output logic                        eq
);

   mmms_pkg::data_type value_ff, value_in;
   logic gt_ff, eq_ff;

   // On insert the values above the key move up one place; the first cell that
   // is either larger than the key or just past the end takes the key itself.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt_ff || tail) begin
            value_in = key;
         end
      end else if (ctrl.remove_en && shift_down) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (ctrl.compare_en) begin
         gt_ff <= occupied && (value_ff > key);
         eq_ff <= occupied && (value_ff == key);
      end
   end

   assign value = value_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for min_max_median_sorted_set: random and directed set operations.
// Keeps its own sorted copy of the set to predict every response.
// Depends on mmms_pkg and the RTL of the block only.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 64;

   typedef struct {
      mmms_pkg::req_type payload;
      int unsigned       gap;
   } request_slot_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   mmms_pkg::req_type req_data  = '0;
   logic              rsp_ready = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   mmms_pkg::rsp_type rsp_data;

   min_max_median_sorted_set #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   request_slot_type   request_backlog[$];
   mmms_pkg::rsp_type  predicted_responses[$];
   mmms_pkg::data_type held_values[$];
   int          error_count   = 0;
   int          item_total    = 0;
   int          results_seen  = 0;
   bit          sender_calm   = 1'b0;

   // Applies one operation to the local copy of the set and returns the response it gives.
   function automatic mmms_pkg::rsp_type apply_set_operation(mmms_pkg::req_type t);
      mmms_pkg::rsp_type r;
      int      pos;
      int      n;
      r = '0;
      r.status = mmms_pkg::STATUS_DONE;
      n = held_values.size();
      case (t.kind)
         mmms_pkg::KIND_INSERT: begin
            pos = 0;
            while (pos < n && held_values[pos] < t.item_value)
               pos++;
            if (pos < n && held_values[pos] == t.item_value)
               r.status = mmms_pkg::STATUS_DUP;
            else if (n >= CAPACITY)
               r.status = mmms_pkg::STATUS_FULL;
            else
               held_values.insert(pos, t.item_value);
         end
         mmms_pkg::KIND_DEL_MIN, mmms_pkg::KIND_DEL_MAX, mmms_pkg::KIND_DEL_MED: begin
            if (n == 0) begin
               r.status = mmms_pkg::STATUS_EMPTY;
            end else begin
               if (t.kind == mmms_pkg::KIND_DEL_MIN)
                  pos = 0;
               else if (t.kind == mmms_pkg::KIND_DEL_MAX)
                  pos = n - 1;
               else
                  pos = (n - 1) / 2;
               r.removed_value = held_values[pos];
               held_values.delete(pos);
            end
         end
         default: begin
            if (n == 0)
               r.status = mmms_pkg::STATUS_EMPTY;
         end
      endcase
      n = held_values.size();
      r.element_count = 7'(n);
      r.set_empty = (n == 0);
      if (n != 0) begin
         r.min_value    = held_values[0];
         r.max_value    = held_values[n - 1];
         r.median_value = held_values[(n - 1) / 2];
      end
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   function automatic mmms_pkg::data_type pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return mmms_pkg::data_type'($urandom_range(0, 16) - 8);
      else if (roll < 45) begin
         case ($urandom_range(0, 4))
            0: return mmms_pkg::data_type'(32'h8000_0000);
            1: return mmms_pkg::data_type'(32'h7fff_ffff);
            2: return mmms_pkg::data_type'(32'hffff_ffff);
            3: return mmms_pkg::data_type'(32'h0000_0001);
            default: return mmms_pkg::data_type'(32'h0000_0000);
         endcase
      end else
         return mmms_pkg::data_type'($urandom());
   endfunction

   task automatic queue_item(logic [2:0] kind, mmms_pkg::data_type value);
      request_slot_type slot;
      slot.payload.kind       = kind;
      slot.payload.item_value = value;
      slot.gap                = pick_gap();
      request_backlog.push_back(slot);
      item_total++;
   endtask

   task automatic check_field(string name, longint want_value, longint got_value);
      if (want_value !== got_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want_value, got_value);
         error_count++;
      end
   endtask

   // Request driver: an item is offered after its idle gap and held until accepted.
   int unsigned      idle_left = 0;
   request_slot_type next_slot;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else begin
         if (req_valid && req_ready)
            predicted_responses.push_back(apply_set_operation(req_data));
         if (!req_valid || req_ready) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               next_slot = request_backlog.pop_front();
               req_data  <= next_slot.payload;
               req_valid <= 1'b1;
               idle_left <= (request_backlog.size() != 0) ? request_backlog[0].gap : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver back-pressure.
   int unsigned       hold_left     = 0;
   bit                long_hold_due = 1'b0;
   int unsigned       ready_roll;
   mmms_pkg::rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               $error("response transaction with nothing outstanding");
               error_count++;
            end else begin
               want = predicted_responses.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("removed_value", want.removed_value, rsp_data.removed_value);
               check_field("element_count", want.element_count, rsp_data.element_count);
               check_field("set_empty", want.set_empty, rsp_data.set_empty);
               check_field("min_value", want.min_value, rsp_data.min_value);
               check_field("max_value", want.max_value, rsp_data.max_value);
               check_field("median_value", want.median_value, rsp_data.median_value);
            end
            results_seen++;
            // Two long hold-offs let the block back up until it refuses requests.
            if (results_seen == 250 || results_seen == 1000)
               long_hold_due = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left <= 299;
            rsp_ready <= 1'b0;
         end else begin
            ready_roll = $urandom_range(0, 99);
            if ((results_seen >= 500 && results_seen < 700) || ready_roll < 70) begin
               rsp_ready <= 1'b1;
            end else if (ready_roll < 95) begin
               rsp_ready <= 1'b0;
               hold_left <= $urandom_range(0, 2);
            end else begin
               rsp_ready <= 1'b0;
               hold_left <= $urandom_range(8, 30);
            end
         end
      end
   end

   initial begin
      #8ms;
      $display("tb: failure");
      $finish;
   end

   int                 mode;
   int                 seg_len;
   int unsigned        roll;
   logic [2:0]         kind;
   logic [31:0]        base;
   mmms_pkg::data_type first_flood;

   initial begin
      // Directed: empty set, extreme values, duplicates, unused kinds, every removal.
      queue_item(mmms_pkg::KIND_PEEK, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MIN, mmms_pkg::data_type'(32'hffff_ffff));
      queue_item(mmms_pkg::KIND_DEL_MAX, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MED, mmms_pkg::data_type'(32'h5555_5555));
      queue_item(3'd5, mmms_pkg::data_type'(32'haaaa_aaaa));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h8000_0000));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h7fff_ffff));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'hffff_ffff));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h0000_0001));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h7fff_ffff));
      queue_item(mmms_pkg::KIND_PEEK, mmms_pkg::data_type'(32'hffff_ffff));
      queue_item(3'd6, mmms_pkg::data_type'(32'h1234_5678));
      queue_item(3'd7, mmms_pkg::data_type'(32'hedcb_a987));
      queue_item(mmms_pkg::KIND_DEL_MED, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MAX, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MIN, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(32'h0000_0005));
      queue_item(mmms_pkg::KIND_DEL_MED, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MAX, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MED, mmms_pkg::data_type'(32'h0000_0000));
      queue_item(mmms_pkg::KIND_DEL_MIN, mmms_pkg::data_type'(32'h0000_0000));

      // Fill past capacity with distinct values, then a duplicate while full.
      for (int i = 0; i < CAPACITY + 6; i++) begin
         base = 32'(i) * 32'h0300_0000 + $urandom_range(0, 32'h00ff_ffff);
         if (i == 0)
            first_flood = mmms_pkg::data_type'(base);
         queue_item(mmms_pkg::KIND_INSERT, mmms_pkg::data_type'(base));
      end
      queue_item(mmms_pkg::KIND_INSERT, first_flood);
      for (int i = 0; i < CAPACITY + 4; i++)
         queue_item(3'($urandom_range(mmms_pkg::KIND_DEL_MIN, mmms_pkg::KIND_DEL_MED)),
                    pick_value());

      // Random segments that grow, shrink or churn the set.
      while (item_total < 1500) begin
         mode    = $urandom_range(0, 3);
         seg_len = $urandom_range(20, 90);
         for (int i = 0; i < seg_len; i++) begin
            sender_calm = (item_total >= 700 && item_total < 900);
            roll = $urandom_range(0, 99);
            case (mode)
               0: kind = (roll < 85) ? mmms_pkg::KIND_INSERT : 3'($urandom_range(0, 7));
               1: kind = (roll < 85)
                         ? 3'($urandom_range(mmms_pkg::KIND_DEL_MIN, mmms_pkg::KIND_DEL_MED))
                         : 3'($urandom_range(0, 7));
               2: kind = (roll < 50) ? mmms_pkg::KIND_INSERT : 3'($urandom_range(0, 7));
               default: kind = 3'($urandom_range(0, 7));
            endcase
            queue_item(kind, pick_value());
         end
      end
      sender_calm = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_valid)
         @(posedge clock);
      while (predicted_responses.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/mmms_pkg.sv
hdl/mmms_cell.sv
hdl/min_max_median_sorted_set.sv
bench/testbench.sv
